// ===== rtl/core/stbs_pkg.sv =====
// package for the sorted table binary search block
// holds field widths, request codes, the search state type and the result struct
// no dependencies
`timescale 1ns / 1ps

package stbs_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 4;
	localparam int CNT_W  = 5;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_SEARCH = 2'b10
	} state_t;

	typedef struct packed {
		logic             valid;
		logic             found;
		logic [IDX_W-1:0] index;
	} result_t;

endpackage

// ===== rtl/core/stbs_ram.sv =====
// generic synchronous ram, one write port and one read port
// read data is registered and appears in the cycle after the read; no dependencies
`timescale 1ns / 1ps

module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/stbs_engine.sv =====
// binary search sequencer: one probe per cycle against the table ram
// depends on stbs_pkg; drives the ram read port, reports a result_t
`timescale 1ns / 1ps

module stbs_engine
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start_search,
	input  logic [$clog2(TABLE_DEPTH):0]   count,
	input  logic signed [DATA_W-1:0]       search_key,
	input  logic signed [DATA_W-1:0]       rdata,
	output logic                           re,
	output logic [$clog2(TABLE_DEPTH)-1:0] raddr,
	output logic                           busy,
	output result_t                        result
);

	localparam int AW = $clog2(TABLE_DEPTH);

	state_t                   state_q;
	logic [AW:0]              lo_q;
	logic [AW:0]              hi_q;   // exclusive upper bound
	logic [AW-1:0]            mid_q;
	logic signed [DATA_W-1:0] key_q;
	logic                     res_valid_q;
	logic                     res_found_q;
	logic [IDX_W-1:0]         res_index_q;

	logic                     hit;
	logic                     greater;
	logic [AW:0]              nlo;
	logic [AW:0]              nhi;
	logic                     more;
	logic [AW+1:0]            nsum;
	logic [AW-1:0]            nmid;
	logic [AW+1:0]            ssum;
	logic [AW-1:0]            smid;

	assign hit     = (rdata == key_q);
	assign greater = (rdata > key_q);

	always_comb begin
		if (greater) begin
			nlo = lo_q;
			nhi = {1'b0, mid_q};
		end else begin
			nlo = {1'b0, mid_q} + (AW+1)'(1);
			nhi = hi_q;
		end
	end

	assign more = (nlo < nhi);
	// floor((lo + hi_incl) / 2) with hi_incl = hi - 1
	assign nsum = (AW+2)'(nlo) + (AW+2)'(nhi) - (AW+2)'(1);
	assign nmid = nsum[AW:1];
	assign ssum = (AW+2)'(count) - (AW+2)'(1);
	assign smid = ssum[AW:1];

	always_comb begin
		re    = 1'b0;
		raddr = smid;
		unique case (state_q)
			ST_IDLE: begin
				re    = start_search && (count != '0);
				raddr = smid;
			end
			ST_SEARCH: begin
				re    = !hit && more;
				raddr = nmid;
			end
			default: begin
				re    = 1'b0;
				raddr = smid;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start_search) begin
						if (count == '0) begin
							res_valid_q <= 1'b1;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (hit || !more) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start_search) begin
					lo_q        <= '0;
					hi_q        <= count;
					mid_q       <= smid;
					key_q       <= search_key;
					res_found_q <= 1'b0;
					res_index_q <= '0;
				end
			end
			ST_SEARCH: begin
				lo_q  <= nlo;
				hi_q  <= nhi;
				mid_q <= nmid;
				if (hit) begin
					res_found_q <= 1'b1;
					res_index_q <= IDX_W'(mid_q);
				end else begin
					res_found_q <= 1'b0;
					res_index_q <= '0;
				end
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign result = {res_valid_q, res_found_q, res_index_q};

	// the probe always lies inside the live range
	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> ((AW+1)'(mid_q) >= lo_q) && ((AW+1)'(mid_q) < hi_q))
		else $error("probe outside search range");

	// a search never runs on an empty range
	a_range_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (lo_q < hi_q))
		else $error("search running on empty range");

	// a miss always reports index zero
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_found_q) |-> (res_index_q == '0))
		else $error("miss with nonzero index");

	// a result only follows a finished search or a request on an empty table
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ($past(state_q) == ST_SEARCH) || $past(start_search && count == '0))
		else $error("result strobe without a search");

	// a search holds the block busy until its result
	a_busy_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start_search && !busy && count != '0) |=> busy)
		else $error("search started without going busy");

endmodule

// ===== rtl/core/sorted_table_binary_search_top.sv =====
// top level of the sorted table binary search block
// depends on stbs_pkg, stbs_ram, stbs_engine
// a write request gives no result; busy stays low
// a search probes the table in ST_SEARCH, one ram probe per cycle, and shows done
// after a hit or an empty range; with no live entries done is shown in the cycle after the request
// a new request is taken in the cycle that done is shown; the receiver cannot stall
// reset clears the control and sets entry_count to 16; table contents are not cleared
`timescale 1ns / 1ps

module sorted_table_binary_search_top
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CNT_W-1:0]         cfg_wdata,
	input  logic                     start,
	output logic                     busy,
	input  logic                     opcode,
	input  logic [IDX_W-1:0]         entry_index,
	input  logic signed [DATA_W-1:0] entry_value,
	input  logic signed [DATA_W-1:0] search_key,
	output logic                     done,
	output logic                     found,
	output logic [IDX_W-1:0]         match_index
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [CNT_W-1:0]         entry_count_q;
	logic                     accept;
	logic                     wr_en;
	logic                     start_search;
	logic [AW:0]              count_sat;
	logic                     re;
	logic [AW-1:0]            raddr;
	logic signed [DATA_W-1:0] rdata;
	result_t                  result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= CNT_W'(16);
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	assign accept       = start && !busy;
	// writes past the table are dropped
	assign wr_en        = accept && (opcode == OP_WRITE) && (32'(entry_index) < TABLE_DEPTH);
	assign start_search = accept && (opcode == OP_SEARCH);
	assign count_sat    = (32'(entry_count_q) > TABLE_DEPTH) ? (AW+1)'(TABLE_DEPTH)
	                                                        : (AW+1)'(entry_count_q);

	stbs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(entry_index)),
		.wdata (entry_value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	stbs_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_search (start_search),
		.count        (count_sat),
		.search_key   (search_key),
		.rdata        (rdata),
		.re           (re),
		.raddr        (raddr),
		.busy         (busy),
		.result       (result)
	);

	assign done        = result.valid;
	assign found       = result.found;
	assign match_index = result.index;

endmodule
